// ----- rtl/iteration_gradient_colormap_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the iteration gradient color map
// Shared helpers that wrap concurrent assertions; they vanish under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ITERATION_GRADIENT_COLORMAP_MACROS_SVH
`define ITERATION_GRADIENT_COLORMAP_MACROS_SVH

`ifndef SYNTH

`define IGC_ASSERT_IMPLY(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("iteration_gradient_colormap: assertion failed");

`define IGC_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("iteration_gradient_colormap: assertion failed");

`else

`define IGC_ASSERT_IMPLY(lbl, clk_sig, rstn_sig, ante, cons)

`define IGC_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons)

`endif

`endif

// ----- rtl/igc_pkg.sv -----
// ----------------------------------------------------------------------------
// igc_pkg
// Types and constants shared by the iteration gradient color map.
// ----------------------------------------------------------------------------
package igc_pkg;

    localparam int SEGMENT_COUNT_DEF = 4;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int CNT_W      = 16;
    localparam int LIMIT_W    = 16;
    localparam int COLOR_W    = 24;
    localparam int CH_W       = 8;
    localparam int CHANNELS   = 3;
    localparam int PIXEL_W    = 32;
    localparam int SEG_OUT_W  = 2;
    localparam int STOP_COUNT = 5;
    localparam int STOP_IDX_W = 3;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = 2;
    localparam int QUEUE_LEVEL_W = 3;

    localparam logic [CH_W-1:0]    ALPHA       = 8'hFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd64;
    localparam logic [STOP_COUNT-1:0][COLOR_W-1:0] STOP_RESET =
        {24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 24'h000000};

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LIMIT = 3'd0,
        REG_STOP0 = 3'd1,
        REG_STOP1 = 3'd2,
        REG_STOP2 = 3'd3,
        REG_STOP3 = 3'd4,
        REG_STOP4 = 3'd5
    } igc_reg_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]                    limit;
        logic [STOP_COUNT-1:0][COLOR_W-1:0]    stops;
    } igc_cfg_t;

endpackage

// ----- rtl/igc_in_if.sv -----
// ----------------------------------------------------------------------------
// igc_in_if
// Input channel: one iteration count per item.
// ----------------------------------------------------------------------------
interface igc_in_if import igc_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] iteration_count;

    modport source (output valid, output iteration_count, input ready);
    modport sink   (input valid, input iteration_count, output ready);

endinterface

// ----- rtl/igc_out_if.sv -----
// ----------------------------------------------------------------------------
// igc_out_if
// Output channel: one packed pixel and its segment per item.
// ----------------------------------------------------------------------------
interface igc_out_if import igc_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [PIXEL_W-1:0]   pixel_rgba;
    logic [SEG_OUT_W-1:0] segment_index;

    modport source (output valid, output pixel_rgba, output segment_index, input ready);
    modport sink   (input valid, input pixel_rgba, input segment_index, output ready);

endinterface

// ----- rtl/igc_regs.sv -----
// ----------------------------------------------------------------------------
// igc_regs
// APB register file holding the iteration limit and the five color stops.
// ----------------------------------------------------------------------------
module igc_regs import igc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output igc_cfg_t              cfg
);

    logic [REG_IDX_W-1:0]               reg_idx;
    logic [STOP_IDX_W-1:0]              stop_idx;
    logic                               wr_en;
    logic [LIMIT_W-1:0]                 limit_reg;
    logic [STOP_COUNT-1:0][COLOR_W-1:0] stops_reg;

    assign reg_idx  = paddr[CFG_ADDR_W-1:2];
    assign stop_idx = STOP_IDX_W'(reg_idx - REG_STOP0);
    assign wr_en    = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            stops_reg <= STOP_RESET;
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_LIMIT)
            begin
                limit_reg <= pwdata[LIMIT_W-1:0];
            end
            else if (reg_idx >= REG_STOP0 && reg_idx <= REG_STOP4)
            begin
                stops_reg[stop_idx] <= pwdata[COLOR_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_LIMIT)
        begin
            prdata = CFG_DATA_W'(limit_reg);
        end
        else if (reg_idx >= REG_STOP0 && reg_idx <= REG_STOP4)
        begin
            prdata = CFG_DATA_W'(stops_reg[stop_idx]);
        end
    end

    assign cfg.limit = limit_reg;
    assign cfg.stops = stops_reg;

endmodule

// ----- rtl/igc_front.sv -----
// ----------------------------------------------------------------------------
// igc_front
// Accepts counts, flags saturation and runs a pipelined restoring divider
// that forms count * SEGMENT_COUNT * 2^FRACTION_BITS / limit, one bit a stage.
// ----------------------------------------------------------------------------
module igc_front import igc_pkg::*;
#(
    parameter  int SEGMENT_COUNT = SEGMENT_COUNT_DEF,
    parameter  int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int SEG_W         = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1,
    localparam int QW            = SEG_W + FRACTION_BITS,
    localparam int DATA_W        = QW + 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    igc_in_if.sink             iter_in,
    input  logic [LIMIT_W-1:0] limit,
    output logic               push_valid,
    input  logic               push_ready,
    output logic [DATA_W-1:0]  push_data
);

    localparam int PROD_W = CNT_W + SEG_W;

    logic               en;
    logic               sat_in;
    logic [PROD_W-1:0]  scaled;

    logic               v_reg    [QW+1];
    logic               sat_reg  [QW+1];
    logic [LIMIT_W-1:0] rem_reg  [QW+1];
    logic [QW-1:0]      tail_reg [QW+1];
    logic [QW-1:0]      quo_reg  [QW+1];

    logic [LIMIT_W:0]   trial    [QW];
    logic               ge       [QW];
    logic [LIMIT_W-1:0] rem_next [QW];

    assign en            = !(v_reg[QW] && !push_ready);
    assign iter_in.ready = en;

    assign scaled = PROD_W'(iter_in.iteration_count) * PROD_W'(SEGMENT_COUNT);
    assign sat_in = (limit == '0) || (iter_in.iteration_count >= limit);

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            trial[k]    = {rem_reg[k], tail_reg[k][QW-1]};
            ge[k]       = trial[k] >= {1'b0, limit};
            rem_next[k] = ge[k] ? LIMIT_W'(trial[k] - {1'b0, limit})
                                : trial[k][LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= iter_in.valid;
            for (int k = 0; k < QW; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0]  <= sat_in;
            rem_reg[0]  <= scaled[PROD_W-1:SEG_W];
            tail_reg[0] <= {scaled[SEG_W-1:0], {FRACTION_BITS{1'b0}}};
            quo_reg[0]  <= '0;
            for (int k = 0; k < QW; k++)
            begin
                sat_reg[k+1]  <= sat_reg[k];
                rem_reg[k+1]  <= rem_next[k];
                tail_reg[k+1] <= tail_reg[k] << 1;
                quo_reg[k+1]  <= {quo_reg[k][QW-2:0], ge[k]};
            end
        end
    end

    assign push_valid = v_reg[QW];
    assign push_data  = {sat_reg[QW], quo_reg[QW]};

endmodule

// ----- rtl/igc_queue.sv -----
// ----------------------------------------------------------------------------
// igc_queue
// Short FIFO that decouples the divider pipeline from the blend stages.
// ----------------------------------------------------------------------------
module igc_queue import igc_pkg::*;
#(
    parameter int WIDTH = 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push_valid,
    output logic                     push_ready,
    input  logic [WIDTH-1:0]         push_data,
    output logic                     pop_valid,
    input  logic                     pop_ready,
    output logic [WIDTH-1:0]         pop_data,
    output logic [QUEUE_LEVEL_W-1:0] level
);

    logic [WIDTH-1:0]         mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_LEVEL_W-1:0] count_reg;
    logic [QUEUE_LEVEL_W-1:0] count_next;
    logic                     push;
    logic                     pop;

    assign push_ready = count_reg != QUEUE_LEVEL_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign level      = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_LEVEL_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_LEVEL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/igc_back.sv -----
// ----------------------------------------------------------------------------
// igc_back
// Picks the two stops of a segment, scales the channel differences by the
// fraction and packs the blended color into the output register.
// ----------------------------------------------------------------------------
module igc_back import igc_pkg::*;
#(
    parameter  int SEGMENT_COUNT = SEGMENT_COUNT_DEF,
    parameter  int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int SEG_W         = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1,
    localparam int QW            = SEG_W + FRACTION_BITS,
    localparam int DATA_W        = QW + 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  logic [DATA_W-1:0] pop_data,
    input  igc_cfg_t          cfg,
    igc_out_if.source         pix_out
);

    localparam int IDX_CW = SEG_W + 2;
    localparam int PRD_W  = CH_W + FRACTION_BITS;

    logic                     en;
    logic                     sat;
    logic [SEG_W-1:0]         seg;
    logic [SEG_W-1:0]         seg_eff;
    logic [FRACTION_BITS-1:0] frac;
    logic [IDX_CW-1:0]        a_raw;
    logic [IDX_CW-1:0]        b_raw;
    logic [IDX_CW-1:0]        a_idx;
    logic [IDX_CW-1:0]        b_idx;
    logic [COLOR_W-1:0]       stop_a;
    logic [COLOR_W-1:0]       stop_b;
    logic [CH_W-1:0]          base  [CHANNELS];
    logic [CH_W-1:0]          tgt   [CHANNELS];
    logic                     dir   [CHANNELS];
    logic [CH_W-1:0]          diff  [CHANNELS];
    logic [CH_W-1:0]          delta [CHANNELS];
    logic [CH_W-1:0]          blend [CHANNELS];
    logic [SEG_W+1:0]         seg_ext;

    logic                     b1_v_reg;
    logic [SEG_W-1:0]         b1_seg_reg;
    logic                     b1_dir_reg  [CHANNELS];
    logic [CH_W-1:0]          b1_base_reg [CHANNELS];
    logic [PRD_W-1:0]         b1_prod_reg [CHANNELS];
    logic                     out_v_reg;
    logic [PIXEL_W-1:0]       pixel_reg;
    logic [SEG_OUT_W-1:0]     seg_out_reg;

    assign en        = !out_v_reg || pix_out.ready;
    assign pop_ready = en;

    assign sat  = pop_data[QW];
    assign seg  = pop_data[QW-1:FRACTION_BITS];
    assign frac = pop_data[FRACTION_BITS-1:0];

    assign seg_eff = sat ? SEG_W'(SEGMENT_COUNT - 1) : seg;
    assign a_raw   = sat ? IDX_CW'(SEGMENT_COUNT) : IDX_CW'(seg);
    assign b_raw   = sat ? IDX_CW'(SEGMENT_COUNT) : IDX_CW'(seg) + IDX_CW'(1);
    assign a_idx   = (a_raw >= IDX_CW'(STOP_COUNT)) ? IDX_CW'(STOP_COUNT - 1) : a_raw;
    assign b_idx   = (b_raw >= IDX_CW'(STOP_COUNT)) ? IDX_CW'(STOP_COUNT - 1) : b_raw;
    assign stop_a  = cfg.stops[a_idx[STOP_IDX_W-1:0]];
    assign stop_b  = cfg.stops[b_idx[STOP_IDX_W-1:0]];

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            base[c]  = stop_a[c*CH_W +: CH_W];
            tgt[c]   = stop_b[c*CH_W +: CH_W];
            dir[c]   = tgt[c] >= base[c];
            diff[c]  = dir[c] ? (tgt[c] - base[c]) : (base[c] - tgt[c]);
            delta[c] = b1_prod_reg[c][FRACTION_BITS +: CH_W];
            blend[c] = b1_dir_reg[c] ? (b1_base_reg[c] + delta[c])
                                     : (b1_base_reg[c] - delta[c]);
        end
    end

    assign seg_ext = {2'b00, b1_seg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_v_reg  <= pop_valid;
            out_v_reg <= b1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_seg_reg <= seg_eff;
            for (int c = 0; c < CHANNELS; c++)
            begin
                b1_dir_reg[c]  <= dir[c];
                b1_base_reg[c] <= base[c];
                b1_prod_reg[c] <= PRD_W'(diff[c]) * PRD_W'(frac);
            end
            pixel_reg   <= {blend[2], blend[1], blend[0], ALPHA};
            seg_out_reg <= seg_ext[SEG_OUT_W-1:0];
        end
    end

    assign pix_out.valid         = out_v_reg;
    assign pix_out.pixel_rgba    = pixel_reg;
    assign pix_out.segment_index = seg_out_reg;

endmodule

// ----- rtl/iteration_gradient_colormap.sv -----
// ----------------------------------------------------------------------------
// iteration_gradient_colormap
// Maps an escape-iteration count to a packed RGBA pixel on a linear gradient.
// ----------------------------------------------------------------------------
// The block takes one count and delivers one pixel per clock while pix_out.ready
// does not stall the output. The position count * SEGMENT_COUNT / limit is
// formed by a pipelined restoring divider that resolves one quotient bit per
// stage, followed by a four-entry queue and two blend stages. A count at or
// above the limit, or a limit of zero, gives the last color stop. Registers sit
// at byte address 4 * index; the user must write them only while no item is in
// flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "iteration_gradient_colormap_macros.svh"

module iteration_gradient_colormap import igc_pkg::*;
#(
    parameter int SEGMENT_COUNT = SEGMENT_COUNT_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    igc_in_if.sink                iter_in,
    igc_out_if.source             pix_out
);

    localparam int SEG_W  = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
    localparam int QW     = SEG_W + FRACTION_BITS;
    localparam int DATA_W = QW + 1;

    igc_cfg_t                 cfg;
    logic                     f_valid;
    logic                     q_ready;
    logic [DATA_W-1:0]        f_data;
    logic                     q_pop_valid;
    logic                     q_pop_ready;
    logic [DATA_W-1:0]        q_pop_data;
    logic [QUEUE_LEVEL_W-1:0] q_level;
    logic [SEG_W:0]           q_seg_wide;

    igc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    igc_front #(
        .SEGMENT_COUNT (SEGMENT_COUNT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .iter_in    (iter_in),
        .limit      (cfg.limit),
        .push_valid (f_valid),
        .push_ready (q_ready),
        .push_data  (f_data)
    );

    igc_queue #(
        .WIDTH (DATA_W)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (q_ready),
        .push_data  (f_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data),
        .level      (q_level)
    );

    igc_back #(
        .SEGMENT_COUNT (SEGMENT_COUNT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .cfg       (cfg),
        .pix_out   (pix_out)
    );

    assign q_seg_wide = {1'b0, q_pop_data[QW-1:FRACTION_BITS]};

    `IGC_ASSERT_IMPLY(a_queue_bound, clk, rst_n, 1'b1, q_level <= QUEUE_LEVEL_W'(QUEUE_DEPTH))
    `IGC_ASSERT_NEXT(a_front_holds, clk, rst_n, f_valid && !q_ready, f_valid)
    `IGC_ASSERT_IMPLY(a_seg_range, clk, rst_n, q_pop_valid && !q_pop_data[QW], q_seg_wide < (SEG_W+1)'(SEGMENT_COUNT))

endmodule
